### hdl/svpt_pkg.sv
// ---------------------------------------------------------------------------
// svpt_pkg: shared types and constants for the scheduled valve pulse timer
// field widths, register codes, reset values and sequencer states
// ---------------------------------------------------------------------------
package svpt_pkg;

    // field widths
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int DAY_W    = 9;
    localparam int MS_W     = 32;
    localparam int MOD_W    = 11;   // minute of day
    localparam int PER_W    = 9;
    localparam int PULSE_W  = 16;
    localparam int CFG_W    = 16;   // widest register
    localparam int CFG_IDX_W = 3;

    // serial datapath
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = MS_W / DIGIT_W;
    localparam int DIV_STEPS = DAY_W;
    localparam int CNT_W     = 4;

    // time constants
    localparam int C_MIN_PER_HOUR = 60;
    localparam int C_DAY_MINUTES  = 1440;
    localparam int C_WRAP_LIMIT   = 1441;

    // register reset values
    localparam logic [MOD_W-1:0]   C_START_RESET  = '0;
    localparam logic [MOD_W-1:0]   C_DUR_RESET    = '0;
    localparam logic [PER_W-1:0]   C_PERIOD_RESET = PER_W'(1);
    localparam logic [PULSE_W-1:0] C_ON_RESET     = PULSE_W'(3000);
    localparam logic [PULSE_W-1:0] C_OFF_RESET    = PULSE_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MINUTE = 3'd0,
        CFG_DURATION     = 3'd1,
        CFG_PERIOD_DAYS  = 3'd2,
        CFG_ON_MS        = 3'd3,
        CFG_OFF_MS       = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_CMP  = 2'd2,
        ST_DONE = 2'd3
    } t_state;

endpackage

### hdl/scheduled_valve_pulse_timer_core.sv
// ---------------------------------------------------------------------------
// scheduled_valve_pulse_timer_core: daily window valve pulse timer
// sequence per input beat: ST_DIV (9 division steps), ST_CMP (8 timestamp digits),
// then ST_DONE until the output register can take the result; no new beat until ST_IDLE
// the work is done by the bit-serial day modulo and the 4-bit digit timestamp unit
// synchronous active-low reset: config registers to defaults, pulse state cleared
// ---------------------------------------------------------------------------
module scheduled_valve_pulse_timer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  svpt_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [svpt_pkg::CFG_W-1:0]    i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [svpt_pkg::HOUR_W-1:0]   i_hour,
    input  logic [svpt_pkg::MINUTE_W-1:0] i_minute,
    input  logic [svpt_pkg::DAY_W-1:0]    i_day_of_year,
    input  logic [svpt_pkg::MS_W-1:0]     i_now_ms,
    input  logic                          i_force_req,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_valve_on
);
    import svpt_pkg::*;

    // configuration registers
    logic [MOD_W-1:0]   r_start;
    logic [MOD_W-1:0]   r_dur;
    logic [PER_W-1:0]   r_period;
    logic [PULSE_W-1:0] r_on;
    logic [PULSE_W-1:0] r_off;

    // persistent pulse state
    logic               r_was_active;
    logic               r_pulse;
    logic [MS_W-1:0]    r_cs;       // cycle start, rotates during digit pass
    logic [MS_W-1:0]    r_ofs;      // next toggle offset, rotates during digit pass

    // per-beat working registers
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [DAY_W-1:0]   r_day;      // dividend, shifted out msb first
    logic [PER_W-1:0]   r_rem;      // partial remainder
    logic [MOD_W-1:0]   r_cur;      // minute of day
    logic               r_force;
    logic               r_active;
    logic [MS_W-1:0]    r_now;      // shifted out lsb digit first
    logic [MS_W-1:0]    r_add;      // addend for the offset
    logic [MS_W-1:0]    r_sum;      // candidate new offset
    logic               r_b1;       // borrow of now - start
    logic               r_b2;       // borrow of elapsed - offset
    logic               r_c;        // carry of offset + addend

    // output register
    logic               r_out_valid;
    logic               r_valve;

    // ---------------------------------------------------------------
    // minute of day at the input, narrow constant multiply
    // ---------------------------------------------------------------
    logic [MOD_W-1:0] in_cur;
    assign in_cur = MOD_W'(MOD_W'(i_hour) * MOD_W'(C_MIN_PER_HOUR)) + MOD_W'(i_minute);

    // ---------------------------------------------------------------
    // daily window test, from registered minute and config
    // ---------------------------------------------------------------
    logic [MOD_W:0] win_end;
    logic [MOD_W:0] cur_x;
    logic           in_win;

    assign win_end = {1'b0, r_start} + {1'b0, r_dur};
    assign cur_x   = {1'b0, r_cur};

    always_comb begin
        if (r_dur == '0) begin
            in_win = 1'b0;
        end else if (win_end <= (MOD_W+1)'(C_DAY_MINUTES)) begin
            in_win = ({1'b0, r_start} <= cur_x) && (cur_x < win_end);
        end else begin
            // window runs past midnight
            in_win = (({1'b0, r_start} <= cur_x) && (cur_x < (MOD_W+1)'(C_WRAP_LIMIT)))
                  || (cur_x < (win_end - (MOD_W+1)'(C_DAY_MINUTES)));
        end
    end

    // ---------------------------------------------------------------
    // one restoring division step per cycle: day mod period
    // ---------------------------------------------------------------
    logic [PER_W:0]   rem_sh;
    logic             rem_ge;
    logic [PER_W-1:0] n_rem;
    logic             n_active;

    assign rem_sh = {r_rem, r_day[DAY_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_period};
    assign n_rem  = rem_ge ? PER_W'(rem_sh - {1'b0, r_period}) : rem_sh[PER_W-1:0];

    // only meaningful on the last division step
    assign n_active = (in_win && (r_period != '0) && (n_rem == '0)) || r_force;

    // ---------------------------------------------------------------
    // timestamp digit unit: elapsed = now - start, compare with offset,
    // and offset + addend formed alongside
    // ---------------------------------------------------------------
    logic                rise;
    logic [DIGIT_W-1:0]  now_d;
    logic [DIGIT_W-1:0]  cse_d;
    logic [DIGIT_W-1:0]  ofe_d;
    logic [DIGIT_W:0]    d1;
    logic [DIGIT_W:0]    d2;
    logic [DIGIT_W:0]    s1;

    assign rise  = r_active && !r_was_active;
    assign now_d = r_now[DIGIT_W-1:0];
    // on a rise the pattern restarts: start = now, offset = 0
    assign cse_d = rise ? now_d : r_cs[DIGIT_W-1:0];
    assign ofe_d = rise ? '0 : r_ofs[DIGIT_W-1:0];
    assign d1 = {1'b0, now_d} - {1'b0, cse_d} - (DIGIT_W+1)'(r_b1);
    assign d2 = {1'b0, d1[DIGIT_W-1:0]} - {1'b0, ofe_d} - (DIGIT_W+1)'(r_b2);
    assign s1 = {1'b0, ofe_d} + {1'b0, r_add[DIGIT_W-1:0]} + (DIGIT_W+1)'(r_c);

    // ---------------------------------------------------------------
    // commit: elapsed >= offset when the final borrow is clear
    // ---------------------------------------------------------------
    logic can_commit;
    logic toggle;
    logic new_pulse;

    assign can_commit = !r_out_valid || i_ready;
    assign toggle     = r_active && !r_b2;
    assign new_pulse  = r_active && (toggle ? !r_pulse : r_pulse);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_cnt == CNT_W'(DIGITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (can_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= C_START_RESET;
            r_dur    <= C_DUR_RESET;
            r_period <= C_PERIOD_RESET;
            r_on     <= C_ON_RESET;
            r_off    <= C_OFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MINUTE: r_start  <= i_cfg_data[MOD_W-1:0];
                CFG_DURATION:     r_dur    <= i_cfg_data[MOD_W-1:0];
                CFG_PERIOD_DAYS:  r_period <= i_cfg_data[PER_W-1:0];
                CFG_ON_MS:        r_on     <= i_cfg_data[PULSE_W-1:0];
                CFG_OFF_MS:       r_off    <= i_cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // working datapath
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt   <= '0;
                r_day   <= i_day_of_year;
                r_rem   <= '0;
                r_cur   <= in_cur;
                r_force <= i_force_req;
                r_now   <= i_now_ms;
                // level after a toggle picks the addend
                r_add   <= MS_W'(r_pulse ? r_off : r_on);
                r_b1    <= 1'b0;
                r_b2    <= 1'b0;
                r_c     <= 1'b0;
            end
            ST_DIV: begin
                r_rem <= n_rem;
                r_day <= {r_day[DAY_W-2:0], 1'b0};
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_cnt    <= '0;
                    r_active <= n_active;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_CMP: begin
                r_cnt <= r_cnt + 1'b1;
                r_now <= {{DIGIT_W{1'b0}}, r_now[MS_W-1:DIGIT_W]};
                r_add <= {{DIGIT_W{1'b0}}, r_add[MS_W-1:DIGIT_W]};
                r_sum <= {s1[DIGIT_W-1:0], r_sum[MS_W-1:DIGIT_W]};
                r_b1  <= d1[DIGIT_W];
                r_b2  <= d2[DIGIT_W];
                r_c   <= s1[DIGIT_W];
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // persistent pulse state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_active <= 1'b0;
            r_pulse      <= 1'b0;
            r_cs         <= '0;
            r_ofs        <= '0;
            r_out_valid  <= 1'b0;
            r_valve      <= 1'b0;
        end else begin
            if (r_state == ST_CMP) begin
                // start and offset rotate back into place over the digit pass
                r_cs  <= {cse_d, r_cs[MS_W-1:DIGIT_W]};
                r_ofs <= {ofe_d, r_ofs[MS_W-1:DIGIT_W]};
            end
            if ((r_state == ST_DONE) && can_commit) begin
                r_was_active <= r_active;
                r_pulse      <= new_pulse;
                if (toggle) begin
                    r_ofs <= r_sum;
                end
                r_out_valid  <= 1'b1;
                r_valve      <= new_pulse;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_valve_on = r_valve;

endmodule
